>>> sv/dihd_pkg.sv
package dihd_pkg;

  // Fixed geometry and sample format
  localparam int SampleBits  = 16;
  localparam int MaxWidth    = 1024;
  localparam int HeightLimit = 1024;
  localparam int StoreDepth  = MaxWidth / 2;
  localparam int AddrBits    = $clog2(StoreDepth);
  localparam int ColBits     = $clog2(MaxWidth);
  localparam int RowBits     = $clog2(HeightLimit);
  localparam int DimBits     = 11;
  localparam int CfgIdxBits  = 2;
  localparam int CntPairBits = 2;
  localparam int CntTotBits  = 3;
  localparam int PairSumBits = SampleBits + 1;
  localparam int TotSumBits  = SampleBits + 2;

  // Reciprocal of three for the three-sample mean
  localparam int RecipShift  = SampleBits + 4;
  localparam int Recip3Bits  = SampleBits + 3;
  localparam int ProdBits    = TotSumBits + Recip3Bits;
  localparam logic [Recip3Bits-1:0] Recip3 =
    Recip3Bits'(((64'd1 << RecipShift) + 64'd2) / 64'd3);

  // Register indexes
  localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_MODE   = 2'd2;

  // Reduction modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_VALID  = 2'd1;
  localparam logic [1:0] MODE_CORNER = 2'd2;

  localparam logic [DimBits-1:0] WidthReset  = 11'd640;
  localparam logic [DimBits-1:0] HeightReset = 11'd480;
  localparam logic [1:0]         ModeReset   = MODE_VALID;

  // Line store entry: even-row pair sum, count and top-left sample
  typedef struct packed {
    logic [PairSumBits-1:0] sum;
    logic [CntPairBits-1:0] cnt;
    logic [SampleBits-1:0]  corner;
    logic                   corner_valid;
  } entry_t;

  localparam int EntryBits = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic reduce;
    logic mul;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic result_item;
    logic out_room;
  } stat_t;

endpackage

>>> sv/dihd_ram.sv
module dihd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write or read one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dihd_ctrl.sv
module dihd_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dihd_pkg::stat_t stat_i,
  output dihd_pkg::cmd_t  cmd_o
);

  dihd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dihd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a result word walks read, multiply and emit
  always_comb begin
    state_d = state_q;
    case (state_q)
      dihd_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.result_item) begin
          state_d = dihd_pkg::ST_READ;
        end
      end
      dihd_pkg::ST_READ: state_d = dihd_pkg::ST_MUL;
      dihd_pkg::ST_MUL:  state_d = dihd_pkg::ST_EMIT;
      dihd_pkg::ST_EMIT: begin
        if (stat_i.out_room) begin
          state_d = dihd_pkg::ST_IDLE;
        end
      end
      default: state_d = dihd_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      dihd_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      dihd_pkg::ST_READ: cmd_o.reduce   = 1'b1;
      dihd_pkg::ST_MUL:  cmd_o.mul      = 1'b1;
      dihd_pkg::ST_EMIT: cmd_o.load_out = stat_i.out_room;
      default: cmd_o = '0;
    endcase
  end

endmodule

>>> sv/dihd_datapath.sv
module dihd_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dihd_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [dihd_pkg::DimBits-1:0]         cfg_data_i,
  input  logic [dihd_pkg::SampleBits-1:0]      sample_i,
  input  logic                                 sample_valid_i,
  input  dihd_pkg::cmd_t                       cmd_i,
  output dihd_pkg::stat_t                      stat_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dihd_pkg::SampleBits-1:0]      reduced_value_o,
  output logic                                 reduced_valid_o,
  output logic                                 frame_last_o
);

  localparam int SB = dihd_pkg::SampleBits;
  localparam int DB = dihd_pkg::DimBits;

  logic [DB-1:0] width_q, height_q;
  logic [1:0]    mode_q;
  logic [DB-1:0] w_eff, h_eff, wp, hp;

  logic [dihd_pkg::ColBits-1:0] col_q;
  logic [dihd_pkg::RowBits-1:0] row_q;
  logic [DB-1:0]                col_ext, row_ext, col_inc, row_inc;
  logic                         in_frame, pair_end;

  logic [SB-1:0] held_s_q;
  logic          held_v_q;
  logic [dihd_pkg::PairSumBits-1:0] pair_sum;
  logic [dihd_pkg::CntPairBits-1:0] pair_cnt;

  logic [dihd_pkg::PairSumBits-1:0] p_sum_q;
  logic [dihd_pkg::CntPairBits-1:0] p_cnt_q;
  logic                             last_q;

  dihd_pkg::entry_t wentry, rentry;
  logic [dihd_pkg::EntryBits-1:0] rdata;
  logic store_we;

  logic [dihd_pkg::TotSumBits-1:0] t_sum_q;
  logic [dihd_pkg::CntTotBits-1:0] t_cnt_q;
  logic [SB-1:0]                   corner_q;
  logic                            cv_q;
  logic [dihd_pkg::ProdBits-1:0]   prod_q;

  logic [SB-1:0] res_val;
  logic          res_ok;
  logic          out_valid_q, ok_q, last_out_q;
  logic [SB-1:0] val_q;

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= dihd_pkg::WidthReset;
      height_q <= dihd_pkg::HeightReset;
      mode_q   <= dihd_pkg::ModeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dihd_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        dihd_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        dihd_pkg::REG_MODE:   mode_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame size and round it down to even
  always_comb begin
    if (width_q < DB'(2)) begin
      w_eff = DB'(2);
    end else if (width_q > DB'(dihd_pkg::MaxWidth)) begin
      w_eff = DB'(dihd_pkg::MaxWidth);
    end else begin
      w_eff = width_q;
    end
    if (height_q < DB'(2)) begin
      h_eff = DB'(2);
    end else if (height_q > DB'(dihd_pkg::HeightLimit)) begin
      h_eff = DB'(dihd_pkg::HeightLimit);
    end else begin
      h_eff = height_q;
    end
    wp = {w_eff[DB-1:1], 1'b0};
    hp = {h_eff[DB-1:1], 1'b0};
  end

  assign col_ext  = DB'(col_q);
  assign row_ext  = DB'(row_q);
  assign col_inc  = col_ext + DB'(1);
  assign row_inc  = row_ext + DB'(1);
  assign in_frame = (col_ext < wp) && (row_ext < hp);
  assign pair_end = in_frame && col_q[0];

  assign stat_o.result_item = pair_end && row_q[0];
  assign stat_o.out_room    = !out_valid_q || out_ready_i;

  // Advance the raster position on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      held_s_q <= '0;
      held_v_q <= 1'b0;
    end else if (cmd_i.accept) begin
      if (col_inc >= w_eff) begin
        col_q <= '0;
        row_q <= (row_inc >= h_eff) ? '0 : row_inc[dihd_pkg::RowBits-1:0];
      end else begin
        col_q <= col_inc[dihd_pkg::ColBits-1:0];
      end
      if (in_frame && !col_q[0]) begin
        held_s_q <= sample_i;
        held_v_q <= sample_valid_i;
      end
    end
  end

  // Pair sum of the held left sample and the current one
  assign pair_sum = (held_v_q ? dihd_pkg::PairSumBits'(held_s_q) : '0) +
                    (sample_valid_i ? dihd_pkg::PairSumBits'(sample_i) : '0);
  assign pair_cnt = dihd_pkg::CntPairBits'(held_v_q) +
                    dihd_pkg::CntPairBits'(sample_valid_i);

  assign wentry.sum          = pair_sum;
  assign wentry.cnt          = pair_cnt;
  assign wentry.corner       = held_s_q;
  assign wentry.corner_valid = held_v_q;
  assign store_we            = cmd_i.accept && pair_end && !row_q[0];

  dihd_ram #(
    .Width (dihd_pkg::EntryBits),
    .Depth (dihd_pkg::StoreDepth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .re_i    (cmd_i.accept && stat_o.result_item),
    .addr_i  (col_q[dihd_pkg::ColBits-1:1]),
    .wdata_i (wentry),
    .rdata_o (rdata)
  );

  assign rentry = dihd_pkg::entry_t'(rdata);

  // Capture the odd-row pair while the store is read
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && stat_o.result_item) begin
      p_sum_q <= pair_sum;
      p_cnt_q <= pair_cnt;
      last_q  <= (row_inc == hp) && (col_inc == wp);
    end
  end

  // Combine both rows of the block
  always_ff @(posedge clk_i) begin
    if (cmd_i.reduce) begin
      t_sum_q  <= dihd_pkg::TotSumBits'(p_sum_q) + dihd_pkg::TotSumBits'(rentry.sum);
      t_cnt_q  <= dihd_pkg::CntTotBits'(p_cnt_q) + dihd_pkg::CntTotBits'(rentry.cnt);
      corner_q <= rentry.corner;
      cv_q     <= rentry.corner_valid;
    end
  end

  // Multiply by the reciprocal of three
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= dihd_pkg::ProdBits'(t_sum_q) * dihd_pkg::ProdBits'(dihd_pkg::Recip3);
    end
  end

  // Select the reduced value by mode
  always_comb begin
    res_val = '0;
    res_ok  = 1'b0;
    case (mode_q)
      dihd_pkg::MODE_PLAIN: begin
        if (t_cnt_q == 3'd4) begin
          res_ok  = 1'b1;
          res_val = t_sum_q[SB+1:2];
        end
      end
      dihd_pkg::MODE_VALID: begin
        res_ok = (t_cnt_q != 3'd0);
        case (t_cnt_q)
          3'd1:    res_val = t_sum_q[SB-1:0];
          3'd2:    res_val = t_sum_q[SB:1];
          3'd3:    res_val = prod_q[dihd_pkg::RecipShift +: SB];
          3'd4:    res_val = t_sum_q[SB+1:2];
          default: res_val = '0;
        endcase
      end
      default: begin
        res_ok  = cv_q;
        res_val = cv_q ? corner_q : '0;
      end
    endcase
  end

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      val_q      <= res_val;
      ok_q       <= res_ok;
      last_out_q <= last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign reduced_value_o = val_q;
  assign reduced_valid_o = ok_q;
  assign frame_last_o    = last_out_q;

endmodule

>>> sv/depth_image_half_downsampler_unit.sv
// Channel  | Handshake                  | Word
// ---------+----------------------------+----------------------------------------
// input    | in_valid_i / in_ready_o    | sample_i, sample_valid_i
// output   | out_valid_o / out_ready_i  | reduced_value_o, reduced_valid_o,
//          |                            | frame_last_o
// config   | cfg_we_i                   | cfg_index_i, cfg_data_i
//
// A word that gives no result leaves the unit ready for the next; a word that
// closes a 2x2 block walks line store read, sum, reciprocal multiply, output load.
// The emit step waits while the output register holds a word not yet taken.
// Reset clears the counters, the held sample and the output valid; the line
// store is not cleared and is always written on the even row before it is read.
module depth_image_half_downsampler_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [dihd_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [dihd_pkg::DimBits-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dihd_pkg::SampleBits-1:0]      sample_i,
  input  logic                                 sample_valid_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dihd_pkg::SampleBits-1:0]      reduced_value_o,
  output logic                                 reduced_valid_o,
  output logic                                 frame_last_o
);

  dihd_pkg::cmd_t  cmd;
  dihd_pkg::stat_t stat;

  dihd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dihd_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (sample_i),
    .sample_valid_i  (sample_valid_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .reduced_value_o (reduced_value_o),
    .reduced_valid_o (reduced_valid_o),
    .frame_last_o    (frame_last_o)
  );

endmodule

>>> sv/dihd_checker.sv
module dihd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [dihd_pkg::SampleBits-1:0] reduced_value_o,
  input logic                            reduced_valid_o,
  input logic                            frame_last_o
);

  // Hold an output word until it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(reduced_value_o) &&
      $stable(reduced_valid_o) && $stable(frame_last_o))
    else $error("output word changed while stalled");

  // An invalid result carries a zero value
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !reduced_valid_o |-> reduced_value_o == '0)
    else $error("invalid result with nonzero value");

  // A new result never follows an input accept directly
  a_rise_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared right after an input accept");

  // A word taken while the input side is open leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o && out_valid_o && out_ready_i |=> !out_valid_o)
    else $error("output reloaded while no block result was pending");

endmodule

bind depth_image_half_downsampler_unit dihd_checker u_dihd_checker (.*);
